### hdl/qfas_pkg.sv
`default_nettype none
package qfas_pkg;

	localparam logic [14:0] ExpMax  = 15'h7FFF;
	localparam logic [127:0] DefNan = {64'h7FFF_8000_0000_0000, 64'h0};
	localparam logic [6:0]  FarShift = 7'd116;

	typedef struct packed {
		logic         spec;     // result fixed at decode
		logic [127:0] specv;
		logic         sign;
		logic         cancel;   // exact cancellation, gives +0
	} ctl_t;

	function automatic logic [6:0] lzc112(input logic [111:0] x);
		logic [6:0] n;
		n = 7'd112;
		for (int i = 0; i < 112; i++)
			if (x[i]) n = 7'(111 - i);
		return n;
	endfunction

	function automatic logic [6:0] lzc117(input logic [116:0] x);
		logic [6:0] n;
		n = 7'd117;
		for (int i = 0; i < 117; i++)
			if (x[i]) n = 7'(116 - i);
		return n;
	endfunction

	// right shift, lost bits OR into bit 0; amt of 116 leaves only the sticky bit
	function automatic logic [115:0] sticky_rshift(input logic [115:0] x,
			input logic [6:0] amt);
		logic [231:0] ext;
		ext = {x, 116'b0} >> amt;
		return ext[231:116] | {115'b0, |ext[115:0]};
	endfunction

endpackage
`default_nettype wire

### hdl/quad_float_add_sub.sv
`default_nettype none
// channel | signals                                   | request moves
// in      | in_valid, in_ready, action, a_hi..b_lo    | one add/sub of two binary128
// out     | out_valid, out_ready, sum_hi, sum_lo      | one rounded binary128 result
//
// Nine register stages: decode, normalize, order, align, add, count, shift,
// underflow, round. One request is taken per cycle while the pipeline advances.
// The pipeline advances as a whole whenever the output register is empty or
// being taken; otherwise every stage holds. arst_n clears the valid bits only.
module quad_float_add_sub (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        action,
	input  wire logic [63:0] a_hi,
	input  wire logic [63:0] a_lo,
	input  wire logic [63:0] b_hi,
	input  wire logic [63:0] b_lo,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      sum_hi,
	output logic [63:0]      sum_lo
);

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	qfas_pkg::ctl_t ctl_d, ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8;

	assign adv      = !v_s9 || out_ready;
	assign in_ready = adv;
	assign out_valid = v_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// ---- decode: classify, special results, subnormal leading zeros
	logic [14:0]  ea, eb;
	logic [111:0] fa, fb;
	logic         sa, sb;
	logic         a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

	always_comb begin
		ea = a_hi[62:48];
		eb = b_hi[62:48];
		fa = {a_hi[47:0], a_lo};
		fb = {b_hi[47:0], b_lo};
		sa = a_hi[63];
		sb = b_hi[63] ^ action;
		a_nan  = (ea == qfas_pkg::ExpMax) && (fa != '0);
		b_nan  = (eb == qfas_pkg::ExpMax) && (fb != '0);
		a_inf  = (ea == qfas_pkg::ExpMax) && (fa == '0);
		b_inf  = (eb == qfas_pkg::ExpMax) && (fb == '0);
		a_zero = (ea == '0) && (fa == '0);
		b_zero = (eb == '0) && (fb == '0);
		ctl_d.spec   = 1'b1;
		ctl_d.sign   = 1'b0;
		ctl_d.cancel = 1'b0;
		priority if (a_nan) begin
			ctl_d.specv = {sa, qfas_pkg::ExpMax, fa | (112'b1 << 111)};
		end else if (b_nan) begin
			// NaN b keeps its own sign
			ctl_d.specv = {b_hi[63], qfas_pkg::ExpMax, fb | (112'b1 << 111)};
		end else if (a_inf) begin
			if (b_inf && (sa != sb)) ctl_d.specv = qfas_pkg::DefNan;
			else ctl_d.specv = {sa, qfas_pkg::ExpMax, 112'b0};
		end else if (b_inf) begin
			ctl_d.specv = {sb, qfas_pkg::ExpMax, 112'b0};
		end else if (a_zero && b_zero) begin
			ctl_d.specv = {sa & sb, 127'b0};
		end else if (b_zero) begin
			ctl_d.specv = {a_hi, a_lo};
		end else begin
			ctl_d.spec  = 1'b0;
			ctl_d.specv = '0;
		end
	end

	logic [14:0]  ea_s1, eb_s1;
	logic [111:0] fa_s1, fb_s1;
	logic         sa_s1, sb_s1, az_s1;
	logic [6:0]   la_s1, lb_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= ctl_d;
			ea_s1 <= ea;
			eb_s1 <= eb;
			fa_s1 <= fa;
			fb_s1 <= fb;
			sa_s1 <= sa;
			sb_s1 <= sb;
			az_s1 <= a_zero;
			la_s1 <= qfas_pkg::lzc112(fa);
			lb_s1 <= qfas_pkg::lzc112(fb);
		end
	end

	// ---- normalize significands, leading one at bit 115; exponents biased, signed
	logic [112:0]        na, nb;
	logic signed [16:0]  xa, xb;

	always_comb begin
		if (ea_s1 == '0) begin
			na = {1'b0, fa_s1} << (la_s1 + 7'd1);
			xa = -$signed({10'b0, la_s1});
		end else begin
			na = {1'b1, fa_s1};
			xa = $signed({2'b0, ea_s1});
		end
		if (eb_s1 == '0) begin
			nb = {1'b0, fb_s1} << (lb_s1 + 7'd1);
			xb = -$signed({10'b0, lb_s1});
		end else begin
			nb = {1'b1, fb_s1};
			xb = $signed({2'b0, eb_s1});
		end
	end

	logic [115:0]       siga_s2, sigb_s2;
	logic signed [16:0] xa_s2, xb_s2;
	logic               sa_s2, sb_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2  <= ctl_s1;
			// zero a takes b's exponent so that b passes through alone
			siga_s2 <= az_s1 ? '0 : {na, 3'b0};
			sigb_s2 <= {nb, 3'b0};
			xa_s2   <= az_s1 ? xb : xa;
			xb_s2   <= xb;
			sa_s2   <= sa_s1;
			sb_s2   <= sb_s1;
		end
	end

	// ---- order by magnitude
	logic a_big;
	assign a_big = (xa_s2 > xb_s2) || ((xa_s2 == xb_s2) && (siga_s2 >= sigb_s2));

	logic [115:0]       big_s3, small_s3;
	logic signed [16:0] x_s3;
	logic [16:0]        diff_s3;
	logic               sub_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s3   <= '{spec: ctl_s2.spec, specv: ctl_s2.specv,
				sign: a_big ? sa_s2 : sb_s2,
				cancel: (sa_s2 != sb_s2) && (xa_s2 == xb_s2) && (siga_s2 == sigb_s2)};
			big_s3   <= a_big ? siga_s2 : sigb_s2;
			small_s3 <= a_big ? sigb_s2 : siga_s2;
			x_s3     <= a_big ? xa_s2 : xb_s2;
			diff_s3  <= a_big ? 17'(xa_s2 - xb_s2) : 17'(xb_s2 - xa_s2);
			sub_s3   <= sa_s2 != sb_s2;
		end
	end

	// ---- align smaller operand
	logic [6:0] dcap;
	assign dcap = (diff_s3 >= 17'(qfas_pkg::FarShift)) ? qfas_pkg::FarShift : diff_s3[6:0];

	logic [115:0]       big_s4, small_s4;
	logic signed [16:0] x_s4;
	logic               sub_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s4   <= ctl_s3;
			big_s4   <= big_s3;
			small_s4 <= qfas_pkg::sticky_rshift(small_s3, dcap);
			x_s4     <= x_s3;
			sub_s4   <= sub_s3;
		end
	end

	// ---- add or subtract magnitudes
	logic [116:0]       mag_s5;
	logic signed [16:0] x_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s5 <= ctl_s4;
			mag_s5 <= sub_s4 ? ({1'b0, big_s4} - {1'b0, small_s4})
			                 : ({1'b0, big_s4} + {1'b0, small_s4});
			x_s5   <= x_s4;
		end
	end

	// ---- leading-zero count
	logic [116:0]       mag_s6;
	logic signed [16:0] x_s6;
	logic [6:0]         z_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s6 <= ctl_s5;
			mag_s6 <= mag_s5;
			x_s6   <= x_s5;
			z_s6   <= qfas_pkg::lzc117(mag_s5);
		end
	end

	// ---- normalize: carry out shifts right one, otherwise left by z-1
	logic [116:0] lsh;
	assign lsh = mag_s6 << (z_s6 - 7'd1);

	logic [115:0]       sig_s7;
	logic signed [16:0] bx_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s7 <= ctl_s6;
			if (z_s6 == '0) begin
				sig_s7 <= mag_s6[116:1] | {115'b0, mag_s6[0]};
			end else begin
				sig_s7 <= lsh[115:0];
			end
			bx_s7 <= x_s6 + 17'sd1 - $signed({10'b0, z_s6});
		end
	end

	// ---- overflow and gradual underflow
	logic signed [16:0] under;
	logic [6:0]         ucap;
	assign under = 17'sd1 - bx_s7;
	assign ucap  = (under >= 17'sd116) ? qfas_pkg::FarShift : under[6:0];

	logic [115:0] sig_s8;
	logic [14:0]  bx_s8;
	logic         inf_s8, zero_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s8  <= ctl_s7;
			inf_s8  <= bx_s7 >= 17'sd32767;
			zero_s8 <= under > 17'sd127;
			if (bx_s7 <= 17'sd0) begin
				sig_s8 <= qfas_pkg::sticky_rshift(sig_s7, ucap);
				bx_s8  <= '0;
			end else begin
				sig_s8 <= sig_s7;
				bx_s8  <= bx_s7[14:0];
			end
		end
	end

	// ---- round to nearest even and pack
	logic         rup;
	logic [116:0] rnd;
	logic [113:0] q;
	logic [15:0]  bexp;
	logic [111:0] frac;
	logic [127:0] res;

	always_comb begin
		rup  = (sig_s8[2:0] > 3'd4) || ((sig_s8[2:0] == 3'd4) && sig_s8[3]);
		rnd  = {1'b0, sig_s8} + (rup ? 117'd8 : 117'd0);
		q    = rnd[116:3];
		bexp = {1'b0, bx_s8};
		frac = q[111:0];
		if (q[113]) begin
			bexp = bexp + 16'd1;
			frac = q[112:1];
		end else if ((bx_s8 == '0) && q[112]) begin
			bexp = 16'd1;   // rounded up out of the subnormal range
		end
		priority if (ctl_s8.spec) begin
			res = ctl_s8.specv;
		end else if (ctl_s8.cancel) begin
			res = '0;
		end else if (inf_s8 || (bexp >= {1'b0, qfas_pkg::ExpMax})) begin
			res = {ctl_s8.sign, qfas_pkg::ExpMax, 112'b0};
		end else if (zero_s8) begin
			res = {ctl_s8.sign, 127'b0};
		end else begin
			res = {ctl_s8.sign, bexp[14:0], frac};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_hi <= res[127:64];
			sum_lo <= res[63:0];
		end
	end

`ifndef SYNTHESIS
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted request did not enter stage 1");

	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (sum_hi[62:48] == qfas_pkg::ExpMax) && ((sum_hi[47:0] != '0) || (sum_lo != '0))
		|-> sum_hi[47])
		else $error("NaN result not quieted");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> (v_s8 == $past(v_s8)) && (v_s1 == $past(v_s1)))
		else $error("pipeline moved while stalled");
`endif

endmodule
`default_nettype wire

### sim/quad_float_add_sub_tb.sv
`timescale 1ns / 100ps
module quad_float_add_sub_tb;

	typedef enum int {OP_ZERO, OP_NORM, OP_INF, OP_NAN} op_kind_e;
	typedef enum logic {ACT_ADD = 1'b0, ACT_SUB = 1'b1} act_e;

	localparam int          BIAS      = 16383;
	localparam int          EXP_TOP   = 32767;
	localparam int          FAR_ALIGN = 130;
	localparam int          WATCHDOG  = 4000;
	localparam logic [127:0] QNAN_DEF = {64'h7FFF_8000_0000_0000, 64'h0};

	// Golden sums plus the checker. Prediction lives here so the class is self-contained.
	class sum_board;
		logic [127:0] pending[$];
		int errors;

		static function int lead_zeros(logic [127:0] x);
			for (int i = 127; i >= 0; i--)
				if (x[i]) return 127 - i;
			return 128;
		endfunction

		static function logic [127:0] shr_jam(logic [127:0] x, int n);
			logic [127:0] r;
			if (n == 0) return x;
			if (n >= 128) return {127'b0, |x};
			r = x >> n;
			if ((x << (128 - n)) != 0) r[0] = 1'b1;
			return r;
		endfunction

		// sig holds three low extra bits (guard, round, sticky)
		static function logic [127:0] norm_round(logic sgn, int ex, logic [127:0] sig);
			int lead, shift, biased, under;
			logic [2:0] grs;
			if (sig == 0) return {sgn, 127'b0};
			lead = 127 - lead_zeros(sig);
			shift = 115 - lead;
			if (shift > 0) sig = sig << shift;
			else if (shift < 0) sig = shr_jam(sig, -shift);
			ex -= shift;
			biased = ex + 115 + BIAS;
			if (biased >= EXP_TOP) return {sgn, 15'h7FFF, 112'b0};
			if (biased <= 0) begin
				under = 1 - biased;
				if (under > 127) return {sgn, 127'b0};
				sig = shr_jam(sig, under);
				biased = 0;
			end
			grs = sig[2:0];
			if (grs > 3'd4 || (grs == 3'd4 && sig[3])) sig = sig + 128'd8;
			sig = sig >> 3;
			if (sig[113]) begin
				sig = sig >> 1;
				biased++;
				if (biased >= EXP_TOP) return {sgn, 15'h7FFF, 112'b0};
			end else if (biased == 0 && sig[112]) begin
				biased = 1;
			end
			return {sgn, biased[14:0], sig[111:0]};
		endfunction

		static function void open_op(logic [127:0] v, output logic sgn, output int ex,
				output logic [127:0] sig, output op_kind_e kind);
			logic [14:0] e;
			logic [127:0] frac;
			int sh;
			e = v[126:112];
			frac = {16'b0, v[111:0]};
			sgn = v[127];
			ex = 0;
			sig = frac;
			kind = OP_NORM;
			if (e == 0) begin
				if (frac == 0) kind = OP_ZERO;
				else begin
					sh = lead_zeros(frac) - 15;
					sig = frac << sh;
					ex = 1 - BIAS - 112 - sh;
				end
			end else if (e == 15'h7FFF) begin
				kind = (frac != 0) ? OP_NAN : OP_INF;
			end else begin
				sig[112] = 1'b1;
				ex = int'(e) - BIAS - 112;
			end
		endfunction

		static function logic [127:0] add_sub_128(logic act, logic [127:0] a, logic [127:0] b);
			logic as, bs;
			int ae, be, diff;
			logic [127:0] am, bm, q;
			op_kind_e ak, bk;
			open_op(a, as, ae, am, ak);
			open_op(b, bs, be, bm, bk);
			if (act == ACT_SUB && bk != OP_NAN) bs = ~bs;
			if (ak == OP_NAN || bk == OP_NAN) begin
				// first NaN wins, comes back quieted
				q = (ak == OP_NAN) ? am : bm;
				q[111] = 1'b1;
				return {(ak == OP_NAN) ? as : bs, 15'h7FFF, q[111:0]};
			end
			if (ak == OP_INF) begin
				if (bk == OP_INF && as != bs) return QNAN_DEF;
				return {as, 15'h7FFF, 112'b0};
			end
			if (bk == OP_INF) return {bs, 15'h7FFF, 112'b0};
			if (ak == OP_ZERO && bk == OP_ZERO) return {as & bs, 127'b0};
			if (ak == OP_ZERO) return norm_round(bs, be - 3, bm << 3);
			if (bk == OP_ZERO) return a;
			am = am << 3; ae -= 3;
			bm = bm << 3; be -= 3;
			diff = ae - be;
			if (diff > 0) begin
				bm = diff > FAR_ALIGN ? {127'b0, |bm} : shr_jam(bm, diff);
				be = ae;
			end else if (diff < 0) begin
				am = -diff > FAR_ALIGN ? {127'b0, |am} : shr_jam(am, -diff);
				ae = be;
			end
			if (as == bs) return norm_round(as, ae, am + bm);
			if (am == bm) return 128'b0;
			if (am > bm) return norm_round(as, ae, am - bm);
			return norm_round(bs, be, bm - am);
		endfunction

		function void note_request(logic act, logic [127:0] a, logic [127:0] b);
			pending.push_back(add_sub_128(act, a, b));
		endfunction

		function void check_sum(logic [63:0] hi, logic [63:0] lo);
			logic [127:0] want;
			if (pending.size() == 0) begin
				$error("unexpected result %h_%h", hi, lo);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (hi !== want[127:64]) begin
				$error("sum_hi expected %h actual %h", want[127:64], hi);
				errors++;
			end
			if (lo !== want[63:0]) begin
				$error("sum_lo expected %h actual %h", want[63:0], lo);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        action = 1'b0;
	logic [63:0] a_hi = '0, a_lo = '0, b_hi = '0, b_lo = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] sum_hi, sum_lo;

	sum_board board = new();
	bit       src_busy_mode = 1'b1;   // redrawn every 200 requests: idle gaps on/off
	bit       snk_busy_mode = 1'b1;
	int       quiet_cycles = 0;

	always #1 clk = ~clk;

	quad_float_add_sub dut (
		.clk, .arst_n, .in_valid, .in_ready, .action, .a_hi, .a_lo, .b_hi, .b_lo,
		.out_valid, .out_ready, .sum_hi, .sum_lo
	);

	function automatic int draw_gap(bit busy);
		return busy ? $urandom_range(0, 16) : 0;
	endfunction

	function automatic logic [127:0] rand128();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	// operand biased toward interesting relations with the partner operand
	function automatic logic [127:0] pick_operand(logic [127:0] other);
		logic [127:0] v;
		int e;
		v = rand128();
		case ($urandom_range(0, 11))
			0: v[126:0] = '0;
			1: v[126:0] = {15'h7FFF, 112'b0};
			2: begin
				v[126:112] = 15'h7FFF;
				if (v[111:0] == 0) v[0] = 1'b1;
			end
			3: v[126:112] = '0;
			4: begin
				// subnormal, fraction shifted right by up to 111 bits
				v[126:112] = '0;
				v[111:0] = v[111:0] >> $urandom_range(0, 111);
			end
			5, 6: begin
				e = int'(other[126:112]) + $urandom_range(0, 6) - 3;
				if (e < 1) e = 1;
				if (e > 32766) e = 32766;
				v[126:112] = e[14:0];
			end
			7: begin
				// near-exact cancellation
				v = other;
				v[127] = $urandom_range(0, 1);
				if ($urandom_range(0, 1)) v[7:0] = v[7:0] ^ 8'($urandom_range(0, 3));
			end
			8: v[126:112] = $urandom_range(0, 1) ? 15'h7FFE : 15'h0001;
			9: begin
				// far alignment
				e = int'(other[126:112]) - $urandom_range(100, 140);
				if (e < 0) e = 0;
				v[126:112] = e[14:0];
			end
			default: ;
		endcase
		return v;
	endfunction

	// Sender: payload and valid move together; at most one update per signal per edge.
	task automatic send_request(logic act, logic [127:0] a, logic [127:0] b);
		action   <= act;
		{a_hi, a_lo} <= a;
		{b_hi, b_lo} <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		board.note_request(act, a, b);
	endtask

	task automatic issue(logic act, logic [127:0] a, logic [127:0] b);
		int gap;
		send_request(act, a, b);
		gap = draw_gap(src_busy_mode);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	// Receiver with random back-pressure
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = draw_gap(snk_busy_mode);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			board.check_sum(sum_hi, sum_lo);
		end
	end

	// Watchdog: cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		logic [127:0] a, b;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: overflow, subnormals, special values, cancellation, alignment, ties
		issue(ACT_ADD, {64'h7FFE_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
			{64'h7FFE_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
		issue(ACT_SUB, {64'h8000_0000_0000_0000, 64'h1}, {64'h0, 64'h1});
		issue(ACT_SUB, {64'h0000_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
			{64'h8000_0000_0000_0000, 64'h1});
		issue(ACT_SUB, {64'h7FFF_0000_0000_0000, 64'h0}, {64'h7FFF_0000_0000_0000, 64'h0});
		issue(ACT_ADD, {64'h7FFF_0000_0000_0000, 64'h0}, {64'hFFFF_0000_0000_0000, 64'h0});
		issue(ACT_ADD, {64'h7FFF_0000_0000_0000, 64'h0}, {64'h3FFF_0000_0000_0000, 64'h5});
		issue(ACT_SUB, {64'h3FFF_0000_0000_0000, 64'h0}, {64'hFFFF_0000_0000_0000, 64'h0});
		issue(ACT_ADD, {64'h7FFF_0000_0000_0000, 64'h1}, {64'hFFFF_8000_0000_0000, 64'h2});
		issue(ACT_SUB, {64'h3FFF_0000_0000_0000, 64'h0}, {64'hFFFF_0000_0000_0000, 64'h9});
		issue(ACT_ADD, {64'h8000_0000_0000_0000, 64'h0}, {64'h8000_0000_0000_0000, 64'h0});
		issue(ACT_SUB, {64'h8000_0000_0000_0000, 64'h0}, {64'h0, 64'h0});
		issue(ACT_SUB, {64'h0, 64'h0}, {64'h0001_0000_0000_0000, 64'h0});
		issue(ACT_ADD, {64'hC123_4567_89AB_CDEF, 64'h0123}, {64'h0, 64'h0});
		issue(ACT_SUB, {64'h4005_1234_0000_0000, 64'h77}, {64'h4005_1234_0000_0000, 64'h77});
		issue(ACT_ADD, {64'h7FFE_0000_0000_0000, 64'h0}, {64'h0000_0000_0000_0000, 64'h1});
		issue(ACT_SUB, {64'h3FFF_0000_0000_0000, 64'h0}, {64'h3F8D_0000_0000_0000, 64'h0});
		issue(ACT_ADD, {64'h3FFF_0000_0000_0000, 64'h0}, {64'h3F8E_0000_0000_0000, 64'h0});
		issue(ACT_ADD, {64'h3FFF_0000_0000_0000, 64'h1}, {64'h3F8E_0000_0000_0000, 64'h0});
		issue(ACT_SUB, {64'h0001_0000_0000_0000, 64'h0}, {64'h0000_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
		issue(ACT_ADD, {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, {64'h0, 64'h0});

		// hold the sender until the pipe is empty
		drain();

		for (int i = 0; i < 1450; i++) begin
			if (i % 200 == 0) begin
				src_busy_mode = $urandom_range(0, 2) != 0;
				snk_busy_mode = $urandom_range(0, 2) != 0;
			end
			a = $urandom_range(0, 3) == 0 ? rand128() : pick_operand(rand128());
			b = pick_operand(a);
			if ($urandom_range(0, 1)) {a, b} = {b, a};
			issue(act_e'($urandom_range(0, 1)), a, b);
		end

		drain();
		repeat (40) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### quad_float_add_sub.f
hdl/qfas_pkg.sv
hdl/quad_float_add_sub.sv
sim/quad_float_add_sub_tb.sv
